>>> rtl/mcb_pkg.sv
// ----------------------------------------------------------------------------
// mcb_pkg
// Shared constants, types and elaboration-time tables for the mu-law
// compand and bit-crush datapath.
// ----------------------------------------------------------------------------
package mcb_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 20;
    localparam int MANT_BITS   = 30;
    localparam int LOG_ROUNDS  = FRAC_BITS;
    localparam int YDIV_STEPS  = 24;
    localparam int ODIV_STEPS  = 30;
    localparam int DEN_W       = 24;

    // configuration register indexes
    localparam logic REG_MU    = 1'b0;
    localparam logic REG_CRUSH = 1'b1;

    localparam logic [7:0] MU_RESET    = 8'd100;
    localparam logic [3:0] CRUSH_RESET = 4'd7;

    typedef logic [DEN_W-1:0]     den_t;
    typedef logic [MANT_BITS:0]   mant_t;
    typedef den_t  den_table_t  [256];
    typedef mant_t root_table_t [FRAC_BITS];

    // per-item control carried alongside the datapath
    typedef struct packed {
        logic       neg;
        logic [7:0] m;
        logic [3:0] cb;
        den_t       den;
    } side_t;

    // integer square root, bit by bit
    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned rem;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        rem  = v;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2 of a small integer, FRAC_BITS fraction bits
    function automatic den_t log2_const(input int unsigned mv);
        longint unsigned m;
        longint unsigned z;
        int              e;
        logic [FRAC_BITS-1:0] frac;
        m    = mv;
        e    = 0;
        frac = '0;
        while (e < 63 && (m >> (e + 1)) != 0) e++;
        z = m << (MANT_BITS - e);
        for (int i = 0; i < FRAC_BITS; i++) begin
            z    = (z * z) >> MANT_BITS;
            frac = {frac[FRAC_BITS-2:0], 1'b0};
            if (z >= (64'd2 << MANT_BITS)) begin
                frac[0] = 1'b1;
                z       = z >> 1;
            end
        end
        return den_t'({e[3:0], frac});
    endfunction

    // log2(1 + mu) for every mu code, zero treated as one
    function automatic den_table_t build_den_table();
        den_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = log2_const((i == 0) ? 2 : i + 1);
        end
        return t;
    endfunction

    // successive square roots of two in Q1.30, entry i-1 holds 2^(2^-i)
    function automatic root_table_t build_root_table();
        root_table_t     t;
        longint unsigned r;
        r = 64'd2 << MANT_BITS;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r    = isqrt64(r << MANT_BITS);
            t[i] = mant_t'(r);
        end
        return t;
    endfunction

    localparam den_table_t  DEN_TABLE  = build_den_table();
    localparam root_table_t ROOT_TABLE = build_root_table();

endpackage

>>> rtl/mcb_if.sv
// ----------------------------------------------------------------------------
// mcb_in_if / mcb_out_if
// Valid/ready sample channels for the compand datapath.
// ----------------------------------------------------------------------------
interface mcb_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mcb_pkg::SAMPLE_BITS-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface mcb_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mcb_pkg::SAMPLE_BITS-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

>>> rtl/mulaw_compand_bitcrush.sv
// ----------------------------------------------------------------------------
// mulaw_compand_bitcrush: mu-law compress, bit-crush, expand; fully pipelined.
// Accepts one sample per cycle while the output buffer has room.
// Rate is set by the single pipeline enable, taken from a 2-entry output buffer.
// rst_n clears all valid bits and the buffer; mu resets to 100, crush_bits to 7.
// ----------------------------------------------------------------------------
module mulaw_compand_bitcrush (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_wdata,
    mcb_in_if.sink           audio_in,
    mcb_out_if.source        audio_out
);

    // configuration registers
    logic [7:0] mu_reg;
    logic [3:0] crush_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg    <= mcb_pkg::MU_RESET;
            crush_reg <= mcb_pkg::CRUSH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcb_pkg::REG_MU:    mu_reg    <= cfg_wdata;
                mcb_pkg::REG_CRUSH: crush_reg <= cfg_wdata[3:0];
                default:            ;
            endcase
        end
    end

    // global pipeline enable from output buffer room
    logic [1:0] fifo_cnt_reg;
    logic [1:0] fifo_cnt_next;
    logic       pipe_en;

    assign pipe_en        = (fifo_cnt_reg != 2'd2);
    assign audio_in.ready = pipe_en;

    // stage 0: magnitude, sign and per-item settings
    logic [15:0]    in_bits;
    logic           s0_vld_reg;
    logic [15:0]    s0_mag_reg;
    mcb_pkg::side_t s0_side_reg;
    mcb_pkg::side_t s0_side_next;

    assign in_bits           = audio_in.in_sample;
    assign s0_side_next.neg  = in_bits[15];
    assign s0_side_next.m    = (mu_reg == 8'd0) ? 8'd1 : mu_reg;
    assign s0_side_next.cb   = crush_reg;
    assign s0_side_next.den  = mcb_pkg::DEN_TABLE[mu_reg];

    // stage 1: full + mu * |x|
    logic           s1_vld_reg;
    logic [23:0]    s1_v_reg;
    mcb_pkg::side_t s1_side_reg;

    // stage 2: leading one and mantissa normalization
    logic           s2_vld_reg;
    logic [3:0]     s2_exp_reg;
    mcb_pkg::mant_t s2_mant_reg;
    mcb_pkg::side_t s2_side_reg;
    logic [3:0]     e_sel;

    always_comb
    begin
        e_sel = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            if (s1_v_reg[15+k]) e_sel = 4'(k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s0_vld_reg <= audio_in.valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_mag_reg  <= in_bits[15] ? (~in_bits + 16'd1) : in_bits;
            s0_side_reg <= s0_side_next;
            s1_v_reg    <= 24'd32768 + (24'(s0_side_reg.m) * 24'(s0_mag_reg));
            s1_side_reg <= s0_side_reg;
            s2_exp_reg  <= e_sel;
            s2_mant_reg <= mcb_pkg::mant_t'({7'b0, s1_v_reg} << (4'd15 - e_sel));
            s2_side_reg <= s1_side_reg;
        end
    end

    // log2 of the expanded magnitude
    logic           lg_vld;
    mcb_pkg::side_t lg_side;
    mcb_pkg::den_t  lg_num;

    mcb_log2 u_log2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (s2_vld_reg),
        .in_side  (s2_side_reg),
        .in_exp   (s2_exp_reg),
        .in_mant  (s2_mant_reg),
        .out_vld  (lg_vld),
        .out_side (lg_side),
        .out_num  (lg_num)
    );

    // compressed level num / den
    logic           yd_vld;
    mcb_pkg::side_t yd_side;
    logic [23:0]    yd_q;

    mcb_ydiv u_ydiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (lg_vld),
        .in_side  (lg_side),
        .in_num   (lg_num),
        .out_vld  (yd_vld),
        .out_side (yd_side),
        .out_q    (yd_q)
    );

    // quantizer step: floor toward minus infinity
    logic [20:0]    y_clamp;
    logic [4:0]     q_shift;
    logic [21:0]    round_add;
    logic [21:0]    k_sum;
    logic [21:0]    k_shifted;
    logic [15:0]    k_mag;
    mcb_pkg::side_t sk_side_next;

    assign y_clamp   = (yd_q > 24'h100000) ? 21'h100000 : yd_q[20:0];
    assign q_shift   = 5'd20 - {1'b0, yd_side.cb};
    assign round_add = yd_side.neg ? ((22'd1 << q_shift) - 22'd1) : 22'd0;
    assign k_sum     = {1'b0, y_clamp} + round_add;
    assign k_shifted = k_sum >> q_shift;
    assign k_mag     = k_shifted[15:0];

    always_comb
    begin
        sk_side_next     = yd_side;
        sk_side_next.neg = yd_side.neg && (k_mag != 16'd0);
    end

    logic           sk_vld_reg;
    logic [15:0]    sk_kmag_reg;
    mcb_pkg::side_t sk_side_reg;
    logic           sm_vld_reg;
    logic [39:0]    sm_prod_reg;
    mcb_pkg::side_t sm_side_reg;
    logic           se_vld_reg;
    logic [23:0]    se_efix_reg;
    mcb_pkg::side_t se_side_reg;
    logic [39:0]    e_shifted;

    assign e_shifted = sm_prod_reg >> sm_side_reg.cb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sk_vld_reg <= 1'b0;
            sm_vld_reg <= 1'b0;
            se_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            sk_vld_reg <= yd_vld;
            sm_vld_reg <= sk_vld_reg;
            se_vld_reg <= sm_vld_reg;
        end
    end

    // step times log2(1+mu), then scale down by steps per unit
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sk_kmag_reg <= k_mag;
            sk_side_reg <= sk_side_next;
            sm_prod_reg <= 40'(sk_kmag_reg) * 40'(sk_side_reg.den);
            sm_side_reg <= sk_side_reg;
            se_efix_reg <= e_shifted[23:0];
            se_side_reg <= sm_side_reg;
        end
    end

    // 2^E
    logic           ex_vld;
    mcb_pkg::side_t ex_side;
    mcb_pkg::mant_t ex_r;
    logic [3:0]     ex_ip;

    mcb_exp2 u_exp2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (se_vld_reg),
        .in_side  (se_side_reg),
        .in_frac  (se_efix_reg[19:0]),
        .in_ip    (se_efix_reg[23:20]),
        .out_vld  (ex_vld),
        .out_side (ex_side),
        .out_r    (ex_r),
        .out_ip   (ex_ip)
    );

    // 2^E - 1 in Q.30
    logic           sp_vld_reg;
    logic [38:0]    sp_diff_reg;
    mcb_pkg::side_t sp_side_reg;
    logic [38:0]    pw;

    assign pw = {8'b0, ex_r} << ex_ip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            sp_vld_reg <= ex_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sp_diff_reg <= pw - (39'd1 << mcb_pkg::MANT_BITS);
            sp_side_reg <= ex_side;
        end
    end

    // divide by mu
    logic           od_vld;
    mcb_pkg::side_t od_side;
    logic [29:0]    od_q;
    logic           od_sat;

    mcb_odiv u_odiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (sp_vld_reg),
        .in_side  (sp_side_reg),
        .in_diff  (sp_diff_reg),
        .out_vld  (od_vld),
        .out_side (od_side),
        .out_q    (od_q),
        .out_sat  (od_sat)
    );

    // round half up to Q1.15, saturate and apply sign
    logic [30:0] r_sum;
    logic [15:0] mag;
    logic [15:0] res_val;

    assign r_sum = {1'b0, od_q} + 31'd16384;
    assign mag   = od_sat ? 16'h8000 : r_sum[30:15];

    always_comb
    begin
        if (od_side.neg)
        begin
            res_val = ~mag + 16'd1;
        end
        else if (mag > 16'h7FFF)
        begin
            res_val = 16'h7FFF;
        end
        else
        begin
            res_val = mag;
        end
    end

    // two-entry output buffer
    logic [15:0] buf_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        push;
    logic        pop;

    assign push = od_vld && pipe_en;
    assign pop  = audio_out.valid && audio_out.ready;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (push && !pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fifo_cnt_next = fifo_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_cnt_reg <= 2'd0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= res_val;
        end
    end

    assign audio_out.valid      = (fifo_cnt_reg != 2'd0);
    assign audio_out.out_sample = buf_reg[rd_ptr_reg];

`ifndef SYNTH
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(s0_vld_reg) && $stable(od_vld) && $stable(sp_vld_reg))
        else $error("pipeline moved while stalled");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (audio_in.valid && audio_in.ready) |=> s0_vld_reg)
        else $error("accepted sample not captured in first stage");
`endif

endmodule

>>> rtl/mcb_log2.sv
// ----------------------------------------------------------------------------
// mcb_log2
// Fraction bits of log2 by repeated squaring, one square per stage.
// ----------------------------------------------------------------------------
module mcb_log2 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  mcb_pkg::side_t     in_side,
    input  logic [3:0]         in_exp,
    input  mcb_pkg::mant_t     in_mant,
    output logic               out_vld,
    output mcb_pkg::side_t     out_side,
    output mcb_pkg::den_t      out_num
);

    localparam int N = mcb_pkg::LOG_ROUNDS;

    logic [N-1:0]                   vld_reg;
    mcb_pkg::side_t                 side_reg [N];
    logic [3:0]                     exp_reg  [N];
    mcb_pkg::mant_t                 z_reg    [N];
    logic [mcb_pkg::FRAC_BITS-1:0]  frac_reg [N];

    for (genvar g = 0; g < N; g++) begin : g_rnd
        logic                          v_src;
        mcb_pkg::side_t                s_src;
        logic [3:0]                    e_src;
        mcb_pkg::mant_t                z_src;
        logic [mcb_pkg::FRAC_BITS-1:0] f_src;
        logic [61:0]                   sq;
        logic [31:0]                   sqt;

        if (g == 0) begin : g_first
            assign v_src = in_vld;
            assign s_src = in_side;
            assign e_src = in_exp;
            assign z_src = in_mant;
            assign f_src = '0;
        end else begin : g_next
            assign v_src = vld_reg[g-1];
            assign s_src = side_reg[g-1];
            assign e_src = exp_reg[g-1];
            assign z_src = z_reg[g-1];
            assign f_src = frac_reg[g-1];
        end

        // square, truncate to Q1.30 and renormalize
        assign sq  = {31'b0, z_src} * {31'b0, z_src};
        assign sqt = sq[61:30];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g] <= s_src;
                exp_reg[g]  <= e_src;
                z_reg[g]    <= sqt[31] ? sqt[31:1] : sqt[30:0];
                frac_reg[g] <= {f_src[mcb_pkg::FRAC_BITS-2:0], sqt[31]};
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_side = side_reg[N-1];
    assign out_num  = {exp_reg[N-1], frac_reg[N-1]};

endmodule

>>> rtl/mcb_ydiv.sv
// ----------------------------------------------------------------------------
// mcb_ydiv
// Restoring divider for the compressed level, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mcb_ydiv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  mcb_pkg::side_t     in_side,
    input  mcb_pkg::den_t      in_num,
    output logic               out_vld,
    output mcb_pkg::side_t     out_side,
    output logic [23:0]        out_q
);

    localparam int N = mcb_pkg::YDIV_STEPS;

    logic [N-1:0]   vld_reg;
    mcb_pkg::side_t side_reg [N];
    logic [23:0]    rem_reg  [N];
    logic [23:0]    q_reg    [N];
    logic [3:0]     lo_reg   [N];

    for (genvar g = 0; g < N; g++) begin : g_step
        logic           v_src;
        mcb_pkg::side_t s_src;
        logic [23:0]    r_src;
        logic [23:0]    q_src;
        logic [3:0]     l_src;
        logic [24:0]    t;
        logic [24:0]    tsub;
        logic           ge;

        if (g == 0) begin : g_first
            // dividend is num shifted up by the fraction width
            assign v_src = in_vld;
            assign s_src = in_side;
            assign r_src = {4'b0, in_num[23:4]};
            assign q_src = '0;
            assign l_src = in_num[3:0];
        end else begin : g_next
            assign v_src = vld_reg[g-1];
            assign s_src = side_reg[g-1];
            assign r_src = rem_reg[g-1];
            assign q_src = q_reg[g-1];
            assign l_src = lo_reg[g-1];
        end

        // trial subtract
        assign t    = {r_src, l_src[3]};
        assign tsub = t - {1'b0, s_src.den};
        assign ge   = (t >= {1'b0, s_src.den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g] <= s_src;
                rem_reg[g]  <= ge ? tsub[23:0] : t[23:0];
                q_reg[g]    <= {q_src[22:0], ge};
                lo_reg[g]   <= {l_src[2:0], 1'b0};
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_side = side_reg[N-1];
    assign out_q    = q_reg[N-1];

endmodule

>>> rtl/mcb_exp2.sv
// ----------------------------------------------------------------------------
// mcb_exp2
// 2^fraction as a product of root constants, one multiply per stage.
// ----------------------------------------------------------------------------
module mcb_exp2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  mcb_pkg::side_t                in_side,
    input  logic [mcb_pkg::FRAC_BITS-1:0] in_frac,
    input  logic [3:0]                    in_ip,
    output logic                          out_vld,
    output mcb_pkg::side_t                out_side,
    output mcb_pkg::mant_t                out_r,
    output logic [3:0]                    out_ip
);

    localparam int N = mcb_pkg::FRAC_BITS;

    logic [N-1:0]   vld_reg;
    mcb_pkg::side_t side_reg [N];
    mcb_pkg::mant_t r_reg    [N];
    logic [N-1:0]   f_reg    [N];
    logic [3:0]     ip_reg   [N];

    for (genvar g = 0; g < N; g++) begin : g_mul
        logic           v_src;
        mcb_pkg::side_t s_src;
        mcb_pkg::mant_t r_src;
        logic [N-1:0]   f_src;
        logic [3:0]     i_src;
        logic [61:0]    prod;

        if (g == 0) begin : g_first
            assign v_src = in_vld;
            assign s_src = in_side;
            assign r_src = mcb_pkg::mant_t'(1) << mcb_pkg::MANT_BITS;
            assign f_src = in_frac;
            assign i_src = in_ip;
        end else begin : g_next
            assign v_src = vld_reg[g-1];
            assign s_src = side_reg[g-1];
            assign r_src = r_reg[g-1];
            assign f_src = f_reg[g-1];
            assign i_src = ip_reg[g-1];
        end

        // multiply by the root for this fraction bit, truncate to Q1.30
        assign prod = {31'b0, r_src} * {31'b0, mcb_pkg::ROOT_TABLE[g]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g] <= s_src;
                r_reg[g]    <= f_src[N-1] ? prod[60:30] : r_src;
                f_reg[g]    <= {f_src[N-2:0], 1'b0};
                ip_reg[g]   <= i_src;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_side = side_reg[N-1];
    assign out_r    = r_reg[N-1];
    assign out_ip   = ip_reg[N-1];

endmodule

>>> rtl/mcb_odiv.sv
// ----------------------------------------------------------------------------
// mcb_odiv
// Divide the expanded value by mu, one quotient bit per stage, with an
// early saturation flag when the quotient would pass full scale.
// ----------------------------------------------------------------------------
module mcb_odiv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  mcb_pkg::side_t     in_side,
    input  logic [38:0]        in_diff,
    output logic               out_vld,
    output mcb_pkg::side_t     out_side,
    output logic [29:0]        out_q,
    output logic               out_sat
);

    localparam int N = mcb_pkg::ODIV_STEPS;

    logic [N-1:0]   vld_reg;
    logic [N-1:0]   sat_reg;
    mcb_pkg::side_t side_reg [N];
    logic [7:0]     rem_reg  [N];
    logic [29:0]    q_reg    [N];
    logic [29:0]    lo_reg   [N];

    for (genvar g = 0; g < N; g++) begin : g_step
        logic           v_src;
        logic           s_sat;
        mcb_pkg::side_t s_src;
        logic [7:0]     r_src;
        logic [29:0]    q_src;
        logic [29:0]    l_src;
        logic [8:0]     t;
        logic [8:0]     tsub;
        logic           ge;

        if (g == 0) begin : g_first
            // quotient reaches 2^30 when the top part already holds mu
            assign v_src = in_vld;
            assign s_src = in_side;
            assign s_sat = (in_diff[38:30] >= {1'b0, in_side.m});
            assign r_src = s_sat ? 8'd0 : in_diff[37:30];
            assign q_src = '0;
            assign l_src = in_diff[29:0];
        end else begin : g_next
            assign v_src = vld_reg[g-1];
            assign s_src = side_reg[g-1];
            assign s_sat = sat_reg[g-1];
            assign r_src = rem_reg[g-1];
            assign q_src = q_reg[g-1];
            assign l_src = lo_reg[g-1];
        end

        // trial subtract
        assign t    = {r_src, l_src[29]};
        assign tsub = t - {1'b0, s_src.m};
        assign ge   = (t >= {1'b0, s_src.m});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g] <= s_src;
                sat_reg[g]  <= s_sat;
                rem_reg[g]  <= ge ? tsub[7:0] : t[7:0];
                q_reg[g]    <= {q_src[28:0], ge};
                lo_reg[g]   <= {l_src[28:0], 1'b0};
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_side = side_reg[N-1];
    assign out_q    = q_reg[N-1];
    assign out_sat  = sat_reg[N-1];

endmodule
